// File: hdl/lcag_pkg.sv
// Shared definitions for the life cellular automaton grid.
// Holds field widths, operation and register codes, and the command and status structs.
// Depends on nothing.
package lcag_pkg;

  localparam int FUNC_W   = 2;
  localparam int ADDR_W   = 5;
  localparam int DIM_REG_W = 6;
  localparam int CFG_IDX_W = 2;
  localparam int DIM_W    = 9;

  localparam int ROWS_DEF = 32;
  localparam int COLS_DEF = 32;

  localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_STEP  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 2'd1;

  localparam logic [DIM_REG_W-1:0] ROWS_USED_RST = 6'd20;
  localparam logic [DIM_REG_W-1:0] COLS_USED_RST = 6'd20;

  typedef struct packed {
    logic in_ready;
    logic latch;
    logic rd_cell;
    logic cell_op;
    logic rd_first;
    logic ld_cur;
    logic rd_next;
    logic calc;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic              in_valid;
    logic [FUNC_W-1:0] func;
    logic              step_empty;
    logic              last_row;
    logic              out_free;
  } sts_t;

endpackage

// File: hdl/lcag_if.sv
// Valid/ready channel interfaces for the life cellular automaton grid.
// Depends on lcag_pkg for the field widths.
interface lcag_in_if;
  logic                        valid;
  logic                        ready;
  logic [lcag_pkg::FUNC_W-1:0] func;
  logic [lcag_pkg::ADDR_W-1:0] row;
  logic [lcag_pkg::ADDR_W-1:0] col;
  logic                        cell_in;

  modport source (output valid, func, row, col, cell_in, input ready);
  modport sink   (input valid, func, row, col, cell_in, output ready);
endinterface

interface lcag_out_if;
  logic valid;
  logic ready;
  logic cell_value;
  logic done_res;

  modport source (output valid, cell_value, done_res, input ready);
  modport sink   (input valid, cell_value, done_res, output ready);
endinterface

// File: hdl/lcag_ctrl.sv
// Sequencer for the life cellular automaton grid.
// Decodes each transaction and walks the row loop of a generation step.
// Depends on lcag_pkg.
module lcag_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  lcag_pkg::sts_t  sts,
  output lcag_pkg::cmd_t  cmd
);

  typedef enum logic [6:0] {
    S_IDLE      = 7'b0000001,
    S_DECODE    = 7'b0000010,
    S_CELL_OP   = 7'b0000100,
    S_STEP_LD0  = 7'b0001000,
    S_STEP_RDN  = 7'b0010000,
    S_STEP_CALC = 7'b0100000,
    S_RESP      = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.in_ready = 1'b1;
        if (sts.in_valid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.func inside {lcag_pkg::FUNC_WRITE, lcag_pkg::FUNC_READ}) begin
          cmd.rd_cell = 1'b1;
          state_nxt   = S_CELL_OP;
        end else if (sts.func == lcag_pkg::FUNC_STEP && !sts.step_empty) begin
          cmd.rd_first = 1'b1;
          state_nxt    = S_STEP_LD0;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_CELL_OP: begin
        cmd.cell_op = 1'b1;
        state_nxt   = S_RESP;
      end
      S_STEP_LD0: begin
        cmd.ld_cur = 1'b1;
        state_nxt  = S_STEP_RDN;
      end
      S_STEP_RDN: begin
        cmd.rd_next = 1'b1;
        state_nxt   = S_STEP_CALC;
      end
      S_STEP_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = sts.last_row ? S_RESP : S_STEP_RDN;
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// File: hdl/lcag_datapath.sv
// Datapath for the life cellular automaton grid: row-wide cell memory with row valid bits,
// a three-row window with the B3/S23 update of a whole row, and the output register.
// Depends on lcag_pkg.
module lcag_datapath #(
  parameter int ROWS = lcag_pkg::ROWS_DEF,
  parameter int COLS = lcag_pkg::COLS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  lcag_pkg::cmd_t                 cmd,
  output lcag_pkg::sts_t                 sts,
  input  logic                           in_valid,
  input  logic [lcag_pkg::FUNC_W-1:0]    in_func,
  input  logic [lcag_pkg::ADDR_W-1:0]    in_row,
  input  logic [lcag_pkg::ADDR_W-1:0]    in_col,
  input  logic                           in_cell_in,
  input  logic [lcag_pkg::DIM_REG_W-1:0] rows_used,
  input  logic [lcag_pkg::DIM_REG_W-1:0] cols_used,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           out_cell_value
);

  localparam int RW = $clog2(ROWS);
  localparam int DW = lcag_pkg::DIM_W;

  logic [COLS-1:0] mem [ROWS];
  logic [ROWS-1:0] row_vld_r;
  logic [COLS-1:0] rd_row_r;
  logic            rd_vld_r;
  logic [COLS-1:0] rd_data;

  logic [lcag_pkg::FUNC_W-1:0] func_r;
  logic [lcag_pkg::ADDR_W-1:0] row_r;
  logic [lcag_pkg::ADDR_W-1:0] col_r;
  logic                        cell_in_r;

  logic [DW-1:0] row_ext, col_ext, ru_ext, cu_ext, nr, nc, r_cnt_r, r_inc;
  logic          addr_ok;

  logic [COLS-1:0] prev_r, cur_r, col_mask, col_hit, nxt_row;
  logic [COLS-1:0] nb_prev, nb_cur, nb_next, life_row, step_row, cell_row;
  logic            rd_bit;

  logic            rd_en;
  logic [RW-1:0]   rd_addr;
  logic            wr_en;
  logic [RW-1:0]   wr_addr;
  logic [COLS-1:0] wr_data;

  logic cell_r;
  logic out_valid_r;
  logic out_cell_r;

  assign row_ext = DW'(row_r);
  assign col_ext = DW'(col_r);
  assign addr_ok = (row_ext < DW'(ROWS)) && (col_ext < DW'(COLS));

  assign ru_ext = DW'(rows_used);
  assign cu_ext = DW'(cols_used);
  assign nr     = (ru_ext > DW'(ROWS)) ? DW'(ROWS) : ru_ext;
  assign nc     = (cu_ext > DW'(COLS)) ? DW'(COLS) : cu_ext;
  assign r_inc  = DW'(r_cnt_r + DW'(1));

  assign sts.in_valid   = in_valid;
  assign sts.func       = func_r;
  assign sts.step_empty = (nr == '0) || (nc == '0);
  assign sts.last_row   = (r_inc == nr);
  assign sts.out_free   = !out_valid_r || out_ready;

  assign rd_data = rd_vld_r ? rd_row_r : '0;

  always_comb begin
    for (int c = 0; c < COLS; c++) begin
      col_mask[c] = DW'(c) < nc;
      col_hit[c]  = DW'(c) == col_ext;
    end
  end

  assign cell_row = (rd_data & ~col_hit) | ({COLS{cell_in_r}} & col_hit);
  assign rd_bit   = |(rd_data & col_hit);

  // Rows beyond the active region count as dead
  assign nxt_row = sts.last_row ? '0 : rd_data;
  assign nb_prev = prev_r & col_mask;
  assign nb_cur  = cur_r & col_mask;
  assign nb_next = nxt_row & col_mask;

  always_comb begin
    logic [3:0] cnt;
    for (int c = 0; c < COLS; c++) begin
      cnt = 4'(nb_prev[c]) + 4'(nb_next[c]);
      if (c > 0) begin
        cnt = cnt + 4'(nb_prev[c-1]) + 4'(nb_cur[c-1]) + 4'(nb_next[c-1]);
      end
      if (c < COLS - 1) begin
        cnt = cnt + 4'(nb_prev[c+1]) + 4'(nb_cur[c+1]) + 4'(nb_next[c+1]);
      end
      life_row[c] = nb_cur[c] ? ((cnt == 4'd2) || (cnt == 4'd3)) : (cnt == 4'd3);
    end
  end

  assign step_row = (life_row & col_mask) | (cur_r & ~col_mask);

  always_comb begin
    rd_en   = cmd.rd_cell || cmd.rd_first || cmd.rd_next;
    rd_addr = row_ext[RW-1:0];
    if (cmd.rd_first) begin
      rd_addr = '0;
    end else if (cmd.rd_next) begin
      rd_addr = r_inc[RW-1:0];
    end
  end

  always_comb begin
    wr_en   = cmd.calc || (cmd.cell_op && func_r == lcag_pkg::FUNC_WRITE && addr_ok);
    wr_addr = cmd.calc ? r_cnt_r[RW-1:0] : row_ext[RW-1:0];
    wr_data = cmd.calc ? step_row : cell_row;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_row_r <= mem[rd_addr];
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (rd_en) begin
        rd_vld_r <= row_vld_r[rd_addr];
      end
      if (wr_en) begin
        row_vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r    <= in_func;
      row_r     <= in_row;
      col_r     <= in_col;
      cell_in_r <= in_cell_in;
      cell_r    <= 1'b0;
    end
    if (cmd.cell_op && func_r == lcag_pkg::FUNC_READ) begin
      cell_r <= addr_ok && rd_bit;
    end
    if (cmd.rd_first) begin
      prev_r  <= '0;
      r_cnt_r <= '0;
    end
    if (cmd.ld_cur) begin
      cur_r <= rd_data;
    end
    if (cmd.calc) begin
      prev_r  <= cur_r;
      cur_r   <= nxt_row;
      r_cnt_r <= r_inc;
    end
    if (cmd.load_out) begin
      out_cell_r <= cell_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_value = out_cell_r;

endmodule

// File: hdl/life_cellular_automaton_grid.sv
// Life cellular automaton grid (B3/S23), top level with configuration registers.
// Cell write and read pass through the decode, cell operation and response states; a
// generation step runs over rows_used rows, capped at ROWS, and a step over an empty
// region or the unused operation code goes straight from decode to the response. The grid
// sits in one memory word per row with one read and one write port, and a step updates one
// whole row per pass through its read and calculate states, through a three-row window.
// Per-row valid bits give the all-dead reset at once, so there is no clearing pass. A
// finished result waits in an output register while the next transaction is accepted.
// Depends on lcag_pkg, lcag_if, lcag_ctrl and lcag_datapath.
module life_cellular_automaton_grid #(
  parameter int ROWS = lcag_pkg::ROWS_DEF,
  parameter int COLS = lcag_pkg::COLS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lcag_in_if.sink                         in_ch,
  lcag_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [lcag_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [lcag_pkg::DIM_REG_W-1:0]  cfg_wdata
);

  lcag_pkg::cmd_t cmd;
  lcag_pkg::sts_t sts;

  logic [lcag_pkg::DIM_REG_W-1:0] rows_used_r;
  logic [lcag_pkg::DIM_REG_W-1:0] cols_used_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_used_r <= lcag_pkg::ROWS_USED_RST;
      cols_used_r <= lcag_pkg::COLS_USED_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        lcag_pkg::CFG_ROWS_USED: rows_used_r <= cfg_wdata;
        lcag_pkg::CFG_COLS_USED: cols_used_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lcag_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  lcag_datapath #(
    .ROWS (ROWS),
    .COLS (COLS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .in_valid       (in_ch.valid),
    .in_func        (in_ch.func),
    .in_row         (in_ch.row),
    .in_col         (in_ch.col),
    .in_cell_in     (in_ch.cell_in),
    .rows_used      (rows_used_r),
    .cols_used      (cols_used_r),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_cell_value (out_ch.cell_value)
  );

  assign in_ch.ready     = cmd.in_ready;
  assign out_ch.done_res = 1'b1;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a transaction is in progress");

  a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_rows_used_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_we && cfg_idx == lcag_pkg::CFG_ROWS_USED) |=> rows_used_r == $past(cfg_wdata))
    else $error("rows_used write lost");

endmodule
